// ===== rtl/core/lsfp_pkg.sv =====
package lsfp_pkg;

    // Frame marker bytes.
    localparam logic [7:0] SYNC_SINGLE_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SINGLE_SECOND = 8'h5A;
    localparam logic [7:0] SYNC_SCAN_FIRST    = 8'hAA;
    localparam logic [7:0] SYNC_SCAN_SECOND   = 8'h55;

    // Widths of the fields and of the counters.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 30;
    localparam int MODE_W   = 2;
    localparam int LIMIT_W  = 10;
    localparam int POS_W    = 4;
    localparam int OUT_TDATA_W = 72;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd50;

    // Header byte positions, counted from the first sync byte.
    localparam logic [POS_W-1:0] POS_FIRST_HDR  = 4'd2;
    localparam logic [POS_W-1:0] POS_LEN_B1     = 4'd3;
    localparam logic [POS_W-1:0] POS_LEN_B2     = 4'd4;
    localparam logic [POS_W-1:0] POS_LEN_B3     = 4'd5;
    localparam logic [POS_W-1:0] POS_SCAN_COUNT = 4'd3;
    localparam logic [POS_W-1:0] POS_ANGLE_LAST = 4'd7;
    localparam logic [POS_W-1:0] POS_CSUM_LAST  = 4'd9;

    // Result kinds carried in tuser.
    localparam logic KIND_SCAN   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT        = 4'd0,
        PH_SEC_A5      = 4'd1,
        PH_SEC_AA      = 4'd2,
        PH_SINGLE_HDR  = 4'd3,
        PH_SINGLE_SKIP = 4'd4,
        PH_SCAN_HDR    = 4'd5,
        PH_SCAN_DATA   = 4'd6
    } phase_t;

    typedef struct packed {
        logic                out_kind;
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_last;
        logic [BYTE_W-1:0]   scan_type;
        logic [BYTE_W-1:0]   sample_count;
        logic [LEN_W-1:0]    resp_length;
        logic [MODE_W-1:0]   resp_mode;
        logic [BYTE_W-1:0]   resp_type;
        logic                length_clamped;
    } result_t;

    // Phase taken when a byte may open a new frame.
    function automatic phase_t start_hunt(input logic [BYTE_W-1:0] b);
        phase_t ph;
        if (b == SYNC_SINGLE_FIRST) begin
            ph = PH_SEC_A5;
        end else if (b == SYNC_SCAN_FIRST) begin
            ph = PH_SEC_AA;
        end else begin
            ph = PH_HUNT;
        end
        return ph;
    endfunction

endpackage

// ===== rtl/core/lidar_serial_frame_parser.sv =====
// Lidar serial deframer. Each input item is one received byte; the block takes
// one byte per clock cycle whenever the result register is empty or being read
// in that same cycle, and a result appears on the output in the cycle after
// the byte that causes it. A5 5A frames yield a single report item (kind 1) after
// their payload has been skipped, at most single_length_limit bytes; AA 55 scan
// frames yield one item (kind 0) per angle and sample byte, the final one with
// tlast set. Checksum bytes are consumed without checking. The length limit is
// written through the cfg channel, which is always ready, and is sampled when
// the last length byte of a frame arrives.
module lidar_serial_frame_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: single_length_limit.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lsfp_pkg::LIMIT_W-1:0]       cfg_data,
    // Input item: [7:0] rx_byte.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lsfp_pkg::BYTE_W-1:0]        s_tdata,
    // Result item: [7:0] data_byte, [15:8] scan_type, [23:16] sample_count,
    // [53:24] resp_length, [55:54] resp_mode, [63:56] resp_type,
    // [64] length_clamped, rest zero.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lsfp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    // tuser: [0] out_kind.
    output logic                               m_tuser
);
    import lsfp_pkg::*;

    logic [LIMIT_W-1:0]  limit_reg;
    logic                byte_accept;
    logic                res_valid;
    logic                can_load;
    result_t             res;

    // Length limit register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    assign s_tready    = can_load;
    assign byte_accept = s_tvalid && can_load;

    lsfp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .rx_byte      (s_tdata),
        .length_limit (limit_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    lsfp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (byte_accept && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/lsfp_parser.sv =====
module lsfp_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_accept,
    input  logic [lsfp_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [lsfp_pkg::LIMIT_W-1:0]  length_limit,
    output logic                          res_valid,
    output lsfp_pkg::result_t             res
);
    import lsfp_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic                clamp_reg,  clamp_next;
    logic [MODE_W-1:0]   mode_reg,   mode_next;
    logic [BYTE_W-1:0]   type_reg,   type_next;
    logic [BYTE_W-1:0]   count_reg,  count_next;
    logic [LIMIT_W-1:0]  skip_reg,   skip_next;

    logic [LEN_W-1:0]    full_len;
    logic [LIMIT_W-1:0]  skip_dec;

    assign full_len = {rx_byte[LEN_W-25:0], len_reg[23:0]};
    assign skip_dec = skip_reg - LIMIT_W'(1);

    // Parser state registers, updated once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
            clamp_reg <= 1'b0;
            mode_reg  <= '0;
            type_reg  <= '0;
            count_reg <= '0;
            skip_reg  <= '0;
        end else if (byte_accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            clamp_reg <= clamp_next;
            mode_reg  <= mode_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            skip_reg  <= skip_next;
        end
    end

    // Next state and the result caused by the current byte.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        clamp_next = clamp_reg;
        mode_next  = mode_reg;
        type_next  = type_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        res_valid  = 1'b0;

        // Scan data layout by default; the report path overrides it.
        res.out_kind       = KIND_SCAN;
        res.data_byte      = rx_byte;
        res.frame_last     = 1'b0;
        res.scan_type      = type_reg;
        res.sample_count   = count_reg;
        res.resp_length    = '0;
        res.resp_mode      = '0;
        res.resp_type      = '0;
        res.length_clamped = 1'b0;

        unique case (phase_reg)
            PH_SEC_A5: begin
                if (rx_byte == SYNC_SINGLE_SECOND) begin
                    phase_next = PH_SINGLE_HDR;
                    pos_next   = POS_FIRST_HDR;
                    len_next   = '0;
                    clamp_next = 1'b0;
                end else begin
                    phase_next = start_hunt(rx_byte);
                end
            end
            PH_SEC_AA: begin
                if (rx_byte == SYNC_SCAN_SECOND) begin
                    phase_next = PH_SCAN_HDR;
                    pos_next   = POS_FIRST_HDR;
                end else begin
                    phase_next = start_hunt(rx_byte);
                end
            end
            PH_SINGLE_HDR: begin
                if (pos_reg <= POS_LEN_B3) begin
                    pos_next = pos_reg + POS_W'(1);
                    unique case (pos_reg)
                        POS_FIRST_HDR: len_next[7:0]   = rx_byte;
                        POS_LEN_B1:    len_next[15:8]  = rx_byte;
                        POS_LEN_B2:    len_next[23:16] = rx_byte;
                        default: begin
                            // Last length byte: top bits carry the mode.
                            len_next  = full_len;
                            mode_next = rx_byte[7:6];
                            if (full_len > LEN_W'(length_limit)) begin
                                skip_next  = length_limit;
                                clamp_next = 1'b1;
                            end else begin
                                skip_next  = full_len[LIMIT_W-1:0];
                                clamp_next = 1'b0;
                            end
                        end
                    endcase
                end else begin
                    // Type byte; with no payload bytes to skip, the report is made at once.
                    type_next = rx_byte;
                    if (skip_reg == '0) begin
                        res_valid          = 1'b1;
                        res.out_kind       = KIND_REPORT;
                        res.data_byte      = '0;
                        res.frame_last     = 1'b1;
                        res.scan_type      = '0;
                        res.sample_count   = '0;
                        res.resp_length    = len_reg;
                        res.resp_mode      = mode_reg;
                        res.resp_type      = rx_byte;
                        res.length_clamped = clamp_reg;
                        phase_next         = PH_HUNT;
                    end else begin
                        phase_next = PH_SINGLE_SKIP;
                    end
                end
            end
            PH_SINGLE_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    res_valid          = 1'b1;
                    res.out_kind       = KIND_REPORT;
                    res.data_byte      = '0;
                    res.frame_last     = 1'b1;
                    res.scan_type      = '0;
                    res.sample_count   = '0;
                    res.resp_length    = len_reg;
                    res.resp_mode      = mode_reg;
                    res.resp_type      = type_reg;
                    res.length_clamped = clamp_reg;
                    phase_next         = PH_HUNT;
                end
            end
            PH_SCAN_HDR: begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_FIRST_HDR) begin
                    type_next = rx_byte;
                end else if (pos_reg == POS_SCAN_COUNT) begin
                    count_next = rx_byte;
                end else if (pos_reg <= POS_ANGLE_LAST) begin
                    // Angle bytes pass through.
                    res_valid      = 1'b1;
                    res.frame_last = (pos_reg == POS_ANGLE_LAST) && (count_reg == '0);
                end else if (pos_reg >= POS_CSUM_LAST) begin
                    // Checksum done: start the samples or end the frame.
                    if (count_reg == '0) begin
                        phase_next = PH_HUNT;
                    end else begin
                        skip_next  = {1'b0, count_reg, 1'b0};
                        phase_next = PH_SCAN_DATA;
                    end
                end
            end
            PH_SCAN_DATA: begin
                skip_next = skip_dec;
                res_valid = 1'b1;
                if (skip_dec == '0) begin
                    res.frame_last = 1'b1;
                    phase_next     = PH_HUNT;
                end
            end
            default: begin
                phase_next = start_hunt(rx_byte);
            end
        endcase
    end

endmodule

// ===== rtl/core/lsfp_out_reg.sv =====
module lsfp_out_reg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    input  lsfp_pkg::result_t                  res,
    output logic                               can_load,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lsfp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import lsfp_pkg::*;

    logic     valid_reg;
    result_t  res_reg;

    // A new result may enter when the register is empty or being drained.
    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.frame_last;
    assign m_tuser  = res_reg.out_kind;
    assign m_tdata  = {7'b0,
                       res_reg.length_clamped,
                       res_reg.resp_type,
                       res_reg.resp_mode,
                       res_reg.resp_length,
                       res_reg.sample_count,
                       res_reg.scan_type,
                       res_reg.data_byte};

endmodule

// ===== tb/tb_lidar_serial_frame_parser.sv =====
module tb_lidar_serial_frame_parser;

    import lsfp_pkg::*;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    lidar_serial_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Bytes waiting for the driver and results the deframer model predicts.
    logic [BYTE_W-1:0] rx_bytes_q[$];
    result_t           pending_results[$];

    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;

    int errors        = 0;
    int bytes_in      = 0;
    int scan_bytes    = 0;
    int reports       = 0;
    int clamped       = 0;
    int limit_writes  = 0;

    // Deframer model state.
    logic [LIMIT_W-1:0] p_limit = LIMIT_RESET;
    phase_t             p_phase = PH_HUNT;
    logic [9:0]         p_pos   = '0;
    logic [31:0]        p_len   = '0;
    logic [1:0]         p_mode  = '0;
    logic [7:0]         p_type  = '0;
    logic [7:0]         p_count = '0;
    logic [9:0]         p_skip  = '0;

    // A byte outside a frame opens one only if it is a start byte.
    function automatic phase_t hunt_phase(input logic [7:0] b);
        if (b == SYNC_SINGLE_FIRST) begin
            return PH_SEC_A5;
        end else if (b == SYNC_SCAN_FIRST) begin
            return PH_SEC_AA;
        end
        return PH_HUNT;
    endfunction

    // Advances the deframer model by one byte; returns 1 when a result is due.
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [9:0]  pos;
        logic [29:0] len;
        bit          emit_report;
        bit          emit_data;
        bit          last;
        r = '0;
        emit_report = 1'b0;
        emit_data = 1'b0;
        last = 1'b0;
        case (p_phase)
            PH_SEC_A5: begin
                if (b == SYNC_SINGLE_SECOND) begin
                    p_phase = PH_SINGLE_HDR;
                    p_pos = 10'(POS_FIRST_HDR);
                    p_len = '0;
                end else begin
                    p_phase = hunt_phase(b);
                end
            end
            PH_SEC_AA: begin
                if (b == SYNC_SCAN_SECOND) begin
                    p_phase = PH_SCAN_HDR;
                    p_pos = 10'(POS_FIRST_HDR);
                end else begin
                    p_phase = hunt_phase(b);
                end
            end
            PH_SINGLE_HDR: begin
                if (p_pos <= POS_LEN_B3) begin
                    p_len = p_len | ({24'd0, b} << ((p_pos - POS_FIRST_HDR) * 8));
                    // The limit is sampled on the last length byte.
                    if (p_pos == POS_LEN_B3) begin
                        len = p_len[29:0];
                        p_mode = b[7:6];
                        if (len > p_limit) begin
                            p_skip = p_limit;
                            p_len = {2'b10, len};
                        end else begin
                            p_skip = len[9:0];
                            p_len = {2'b00, len};
                        end
                    end
                    p_pos = p_pos + 1'b1;
                end else begin
                    p_type = b;
                    if (p_skip == 0) begin
                        emit_report = 1'b1;
                    end else begin
                        p_phase = PH_SINGLE_SKIP;
                    end
                end
            end
            PH_SINGLE_SKIP: begin
                p_skip = p_skip - 1'b1;
                emit_report = (p_skip == 0);
            end
            PH_SCAN_HDR: begin
                pos = p_pos;
                p_pos = p_pos + 1'b1;
                if (pos == POS_FIRST_HDR) begin
                    p_type = b;
                end else if (pos == POS_SCAN_COUNT) begin
                    p_count = b;
                end else if (pos <= POS_ANGLE_LAST) begin
                    emit_data = 1'b1;
                    last = (pos == POS_ANGLE_LAST) && (p_count == 0);
                end else if (pos >= POS_CSUM_LAST) begin
                    if (p_count == 0) begin
                        p_phase = PH_HUNT;
                    end else begin
                        p_skip = {1'b0, p_count, 1'b0};
                        p_phase = PH_SCAN_DATA;
                    end
                end
            end
            PH_SCAN_DATA: begin
                p_skip = p_skip - 1'b1;
                emit_data = 1'b1;
                if (p_skip == 0) begin
                    last = 1'b1;
                    p_phase = PH_HUNT;
                end
            end
            default: begin
                p_phase = hunt_phase(b);
            end
        endcase
        if (emit_report) begin
            r.out_kind = KIND_REPORT;
            r.frame_last = 1'b1;
            r.resp_length = p_len[29:0];
            r.resp_mode = p_mode;
            r.resp_type = p_type;
            r.length_clamped = p_len[31];
            p_phase = PH_HUNT;
        end else if (emit_data) begin
            r.out_kind = KIND_SCAN;
            r.data_byte = b;
            r.frame_last = last;
            r.scan_type = p_type;
            r.sample_count = p_count;
        end
        return emit_report || emit_data;
    endfunction

    // Byte driver: holds a byte until it is taken, idles at random otherwise.
    always @(posedge aclk) begin : byte_driver
        result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                bytes_in++;
                if (deframe_byte(s_tdata, res)) begin
                    pending_results.push_back(res);
                end
            end
            if (!s_tvalid || s_tready) begin
                if (rx_bytes_q.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= rx_bytes_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Result monitor: compares each taken item with the oldest prediction.
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_kind", want.out_kind, m_tuser);
                    check_field("frame_last", want.frame_last, m_tlast);
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("scan_type", want.scan_type, m_tdata[15:8]);
                    check_field("sample_count", want.sample_count, m_tdata[23:16]);
                    check_field("resp_length", want.resp_length, m_tdata[53:24]);
                    check_field("resp_mode", want.resp_mode, m_tdata[55:54]);
                    check_field("resp_type", want.resp_type, m_tdata[63:56]);
                    check_field("length_clamped", want.length_clamped, m_tdata[64]);
                    check_field("tdata padding", '0, m_tdata[OUT_TDATA_W-1:65]);
                    if (want.out_kind == KIND_REPORT) begin
                        reports++;
                        clamped += want.length_clamped;
                    end else begin
                        scan_bytes++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 19);
        end
    end

    // Writes the length limit; only called once all queued traffic has drained.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        p_limit = value;
        limit_writes++;
    endtask

    // Waits until all bytes are taken and all predicted results have arrived.
    task automatic wait_drained();
        int n;
        do @(posedge aclk); while (rx_bytes_q.size() != 0 || s_tvalid);
        n = 0;
        while (pending_results.size() != 0 && n < 300) begin
            @(posedge aclk);
            n++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results missing, expected next %p, actual none", $time,
                     pending_results.size(), pending_results[0]);
            errors++;
            pending_results.delete();
        end
        // Allow the registered result path to settle before any register write.
        repeat (4) @(posedge aclk);
    endtask

    // Single-response frame; its length is mostly within or just past the limit.
    task automatic add_single();
        logic [29:0] len;
        logic [1:0]  mode;
        int          k;
        int          n;
        k = $urandom_range(99);
        if (k < 70) begin
            len = 30'($urandom_range(p_limit < 40 ? p_limit : 40));
        end else if (k < 85) begin
            len = 30'(p_limit + $urandom_range(1));
        end else begin
            len = 30'($urandom);
        end
        mode = 2'($urandom_range(3));
        rx_bytes_q = {rx_bytes_q, SYNC_SINGLE_FIRST, SYNC_SINGLE_SECOND, len[7:0], len[15:8],
                      len[23:16], {mode, len[29:24]}, 8'($urandom_range(255))};
        n = (len > p_limit) ? int'(p_limit) : int'(len);
        repeat (n) rx_bytes_q.push_back(8'($urandom_range(255)));
    endtask

    // Scan frame with mostly short sample runs and now and then a long one.
    task automatic add_scan();
        int count;
        count = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
        rx_bytes_q = {rx_bytes_q, SYNC_SCAN_FIRST, SYNC_SCAN_SECOND,
                      8'($urandom_range(255)), 8'(count)};
        repeat (6 + 2 * count) rx_bytes_q.push_back(8'($urandom_range(255)));
    endtask

    // Loose bytes, cut-off frames and start bytes with a wrong partner.
    task automatic add_noise();
        case ($urandom_range(3))
            0: repeat ($urandom_range(4, 1)) rx_bytes_q.push_back(8'($urandom_range(255)));
            1: begin
                rx_bytes_q = {rx_bytes_q, SYNC_SINGLE_FIRST, SYNC_SINGLE_SECOND};
                repeat ($urandom_range(4)) rx_bytes_q.push_back(8'($urandom_range(255)));
            end
            2: begin
                rx_bytes_q = {rx_bytes_q, SYNC_SCAN_FIRST, SYNC_SCAN_SECOND};
                repeat ($urandom_range(8)) rx_bytes_q.push_back(8'($urandom_range(255)));
            end
            default: begin
                rx_bytes_q.push_back($urandom_range(1) ? SYNC_SINGLE_FIRST : SYNC_SCAN_FIRST);
                case ($urandom_range(2))
                    0: rx_bytes_q.push_back(SYNC_SINGLE_FIRST);
                    1: rx_bytes_q.push_back(SYNC_SCAN_FIRST);
                    default: rx_bytes_q.push_back(8'($urandom_range(255)));
                endcase
            end
        endcase
    endtask

    // Queues random traffic of about the given number of bytes and drains it.
    task automatic run_random(input int budget);
        int k;
        @(negedge aclk);
        while (rx_bytes_q.size() < budget) begin
            k = $urandom_range(99);
            if (k < 35) begin
                add_single();
            end else if (k < 80) begin
                add_scan();
            end else begin
                add_noise();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limit: bad partner bytes, a zero-length report, a scan without samples.
        @(negedge aclk);
        rx_bytes_q = {SYNC_SINGLE_FIRST, 8'h33,
                      SYNC_SCAN_FIRST, SYNC_SINGLE_FIRST, SYNC_SINGLE_SECOND,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'hC3,
                      SYNC_SCAN_FIRST, SYNC_SCAN_SECOND, 8'hFF, 8'h00,
                      8'h01, 8'h02, 8'h03, 8'h04, 8'hEE, 8'hEE};
        wait_drained();
        run_random(300);

        // Small limit: the largest length field gets clamped; a one-sample scan.
        write_limit(10'd2);
        @(negedge aclk);
        rx_bytes_q = {SYNC_SINGLE_FIRST, SYNC_SINGLE_SECOND, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h11, 8'h22,
                      SYNC_SCAN_FIRST, SYNC_SCAN_FIRST, SYNC_SCAN_SECOND, 8'h00, 8'h01,
                      8'h80, 8'h40, 8'h20, 8'h10, 8'hFF, 8'hFF, 8'h7F, 8'h80};
        wait_drained();

        write_limit(10'd0);
        run_random(250);
        // Frames near the top limit are long, so this run gets a small budget.
        write_limit(10'd1023);
        run_random(100);

        // A stretch with no idle cycles on either side.
        write_limit(10'($urandom_range(100, 1)));
        @(negedge aclk);
        steady = 1'b1;
        run_random(350);
        @(negedge aclk);
        steady = 1'b0;

        write_limit(10'd7);
        run_random(250);

        repeat (8) @(posedge aclk);
        $display("Sent %0d bytes over %0d limit settings.", bytes_in, limit_writes + 1);
        $display("Checked %0d scan bytes and %0d reports, %0d of them clamped.",
                 scan_bytes, reports, clamped);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d bytes queued and %0d results outstanding.",
                 rx_bytes_q.size(), pending_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lsfp_pkg.sv
rtl/core/lsfp_parser.sv
rtl/core/lsfp_out_reg.sv
rtl/core/lidar_serial_frame_parser.sv
tb/tb_lidar_serial_frame_parser.sv
